// File: rtl/core/assert_macros.svh
// Assertion macros shared by the interval selection RTL.
// Compiled out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ISS_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");
`define ISS_ASSERT_R(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");
`else
`define ISS_ASSERT(name, clk, rst, prop)
`define ISS_ASSERT_R(name, clk, prop)
`endif
`endif

// File: rtl/core/iss_pkg.sv
// Package for interval_schedule_select: word types and fixed widths.
// No dependencies.
package iss_pkg;
   localparam int FIELD_TIME_W = 16;
   localparam int NUM_W        = 7;

   typedef struct packed {
      logic [FIELD_TIME_W-1:0] start_time;
      logic [FIELD_TIME_W-1:0] end_time;
      logic                    last_interval;
   } req_type;

   typedef struct packed {
      logic [NUM_W-1:0] interval_number;
      logic             last_result;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      logic [NUM_W-1:0] count;
      logic             dropped;
   } job_type;
endpackage

// File: rtl/core/interval_schedule_select.sv
// interval_schedule_select: earliest-finish greedy interval selection.
// Intervals load at one word per cycle. After the last-marked word, the loader
// stalls while the selector runs: each pick is one pass over the n stored
// intervals through the single memory read port, and a set with k picks
// takes k + 1 passes, the last of which finds no further interval.
module interval_schedule_select #(
   parameter int MAX_INTERVALS = 64,
   parameter int TIME_BITS     = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  iss_pkg::req_type req_word,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output iss_pkg::rsp_type rsp_word
);
   import iss_pkg::*;

   localparam int IDX_W = $clog2(MAX_INTERVALS);

   logic                 push, pop, q_empty, back_busy;
   job_type              push_job, head_job;
   logic [IDX_W-1:0]     rd_addr;
   logic [TIME_BITS-1:0] rd_start, rd_end;

   iss_front #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_BITS(TIME_BITS)) u_front (
      .clock, .reset, .req_valid, .req_stall, .req_word,
      .job_pending(!q_empty || back_busy),
      .push, .push_job, .rd_addr, .rd_start, .rd_end
   );

   iss_queue u_queue (
      .clock, .reset, .push, .push_job, .pop, .empty(q_empty), .head_job
   );

   iss_back #(.MAX_INTERVALS(MAX_INTERVALS), .TIME_BITS(TIME_BITS)) u_back (
      .clock, .reset, .q_empty, .head_job, .pop, .busy(back_busy),
      .rd_addr, .rd_start, .rd_end, .rsp_valid, .rsp_stall, .rsp_word
   );
endmodule

// File: rtl/core/iss_front.sv
// Loader: stores intervals into the time memories and posts a job per set.
// Depends on iss_pkg.
module iss_front #(
   parameter int MAX_INTERVALS = 64,
   parameter int TIME_BITS     = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  iss_pkg::req_type                req_word,
   input  logic                            job_pending,
   output logic                            push,
   output iss_pkg::job_type                push_job,
   input  logic [$clog2(MAX_INTERVALS)-1:0] rd_addr,
   output logic [TIME_BITS-1:0]            rd_start,
   output logic [TIME_BITS-1:0]            rd_end
);
   import iss_pkg::*;

   localparam int IDX_W = $clog2(MAX_INTERVALS);
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

   logic [TIME_BITS-1:0] start_mem [MAX_INTERVALS];
   logic [TIME_BITS-1:0] end_mem   [MAX_INTERVALS];
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic                 accept, room;
   logic [TIME_BITS-1:0] rd_start_ff, rd_end_ff;

   assign req_stall = job_pending;
   assign accept    = req_valid && !req_stall;
   assign room      = count_ff < CNT_W'(MAX_INTERVALS);

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (accept) begin
         if (room) count_in = count_ff + CNT_W'(1);
         else drop_in = 1'b1;
         if (req_word.last_interval) begin
            count_in = '0;
            drop_in  = 1'b0;
         end
      end
   end

   assign push           = accept && req_word.last_interval;
   assign push_job.count = NUM_W'(room ? count_ff + CNT_W'(1) : count_ff);
   assign push_job.dropped = drop_ff || !room;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         drop_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         drop_ff  <= drop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         start_mem[count_ff[IDX_W-1:0]] <= TIME_BITS'(req_word.start_time);
         end_mem[count_ff[IDX_W-1:0]]   <= TIME_BITS'(req_word.end_time);
      end
      rd_start_ff <= start_mem[rd_addr];
      rd_end_ff   <= end_mem[rd_addr];
   end

   assign rd_start = rd_start_ff;
   assign rd_end   = rd_end_ff;
endmodule

// File: rtl/core/iss_queue.sv
// Two-entry job queue between loader and selector.
// Depends on iss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iss_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  iss_pkg::job_type push_job,
   input  logic             pop,
   output logic             empty,
   output iss_pkg::job_type head_job
);
   import iss_pkg::*;

   job_type    slot_ff [2];
   logic       wr_ff, rd_ff;
   logic [1:0] fill_ff;

   assign empty    = fill_ff == 2'd0;
   assign head_job = slot_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= 1'b0;
         rd_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop)  rd_ff <= !rd_ff;
         if (push && !pop) fill_ff <= fill_ff + 2'd1;
         else if (pop && !push) fill_ff <= fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_job;
   end

   `ISS_ASSERT(no_overrun, clock, reset, push && !pop |-> fill_ff != 2'd2)
   `ISS_ASSERT(no_underrun, clock, reset, pop |-> !empty)
   `ISS_ASSERT(fill_bound, clock, reset, fill_ff != 2'd3)
endmodule

// File: rtl/core/iss_back.sv
// Selector: repeated minimum scans over stored intervals, greedy pick, output register.
// Depends on iss_pkg and assert_macros.svh.
`include "assert_macros.svh"
module iss_back #(
   parameter int MAX_INTERVALS = 64,
   parameter int TIME_BITS     = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_empty,
   input  iss_pkg::job_type                 head_job,
   output logic                             pop,
   output logic                             busy,
   output logic [$clog2(MAX_INTERVALS)-1:0] rd_addr,
   input  logic [TIME_BITS-1:0]             rd_start,
   input  logic [TIME_BITS-1:0]             rd_end,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output iss_pkg::rsp_type                 rsp_word
);
   import iss_pkg::*;

   localparam int IDX_W = $clog2(MAX_INTERVALS);
   localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0]           state_ff;
   logic [CNT_W-1:0]     n_ff, issue_ff;
   logic                 ovf_ff, chk_vld_ff, first_ff, found_ff;
   logic [IDX_W-1:0]     chk_idx_ff, best_idx_ff, prev_idx_ff, pend_idx_ff;
   logic [TIME_BITS-1:0] best_end_ff, limit_ff, prev_end_ff;
   logic                 pend_vld_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_word_ff;
   logic                 out_free, elig, better, out_load, out_last;

   assign busy      = state_ff != ST_IDLE;
   assign pop       = state_ff == ST_IDLE && !q_empty;
   assign rd_addr   = issue_ff[IDX_W-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign elig = first_ff || (rd_start >= limit_ff &&
      (rd_end > prev_end_ff || (rd_end == prev_end_ff && chk_idx_ff > prev_idx_ff)));
   assign better = !found_ff || rd_end < best_end_ff;

   always_comb begin
      out_load = 1'b0;
      out_last = 1'b0;
      if (state_ff == ST_FIN && out_free) begin
         if (found_ff) out_load = pend_vld_ff;
         else begin
            out_load = 1'b1;
            out_last = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         chk_vld_ff   <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         first_ff     <= 1'b0;
         issue_ff     <= '0;
      end else begin
         if (out_load) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
         chk_vld_ff <= state_ff == ST_SCAN && issue_ff < n_ff;
         case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  state_ff    <= ST_SCAN;
                  issue_ff    <= '0;
                  first_ff    <= 1'b1;
                  found_ff    <= 1'b0;
                  pend_vld_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (issue_ff < n_ff) issue_ff <= issue_ff + CNT_W'(1);
               if (chk_vld_ff && elig && better) found_ff <= 1'b1;
               if (issue_ff == n_ff && !chk_vld_ff) state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (found_ff && (!pend_vld_ff || out_free)) begin
                  pend_vld_ff <= 1'b1;
                  first_ff    <= 1'b0;
                  found_ff    <= 1'b0;
                  issue_ff    <= '0;
                  state_ff    <= ST_SCAN;
               end else if (!found_ff && out_free) begin
                  pend_vld_ff <= 1'b0;
                  state_ff    <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         n_ff   <= CNT_W'(head_job.count);
         ovf_ff <= head_job.dropped;
      end
      chk_idx_ff <= issue_ff[IDX_W-1:0];
      if (state_ff == ST_SCAN && chk_vld_ff && elig && better) begin
         best_end_ff <= rd_end;
         best_idx_ff <= chk_idx_ff;
      end
      if (state_ff == ST_FIN && found_ff && (!pend_vld_ff || out_free)) begin
         pend_idx_ff <= best_idx_ff;
         limit_ff    <= best_end_ff;
         prev_end_ff <= best_end_ff;
         prev_idx_ff <= best_idx_ff;
      end
      if (out_load) begin
         rsp_word_ff.interval_number <= NUM_W'(pend_idx_ff) + NUM_W'(1);
         rsp_word_ff.last_result     <= out_last;
         rsp_word_ff.overflow        <= ovf_ff;
      end
   end

   `ISS_ASSERT(load_only_busy, clock, reset, out_load |-> state_ff == ST_FIN && pend_vld_ff)
   `ISS_ASSERT(pop_only_idle, clock, reset, pop |=> state_ff == ST_SCAN)
   `ISS_ASSERT(last_ends_run, clock, reset, out_load && out_last |=> state_ff == ST_IDLE)
endmodule

// File: tb/tb_interval_schedule_select.sv
// Testbench for interval_schedule_select: loads interval sets, predicts the greedy
// earliest-finish picks and checks every result word. Depends on iss_pkg and the RTL.
`timescale 1ns / 1ps

module tb_interval_schedule_select;
   import iss_pkg::*;

   localparam int CAP = 64;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_word;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_word;

   interval_schedule_select u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word)
   );

   req_type pending_words[$];
   int      pause_marks[$];
   rsp_type expected_picks[$];

   logic [15:0] set_start[CAP];
   logic [15:0] set_end[CAP];
   int          set_count;
   logic        set_dropped;
   logic [15:0] finish_mark;

   bit   quiet_mode;
   int   errors;
   int   words_sent;
   int   picks_seen;
   int   sets_done;
   bit   hold_send;

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // Predict one accepted word; on the last word emit the greedy picks.
   task automatic predict_word(input req_type w);
      int order[CAP];
      int i, j, key, idx, n;
      rsp_type r;
      bit any;
      begin
         if (set_count < CAP) begin
            set_start[set_count] = w.start_time;
            set_end[set_count] = w.end_time;
            set_count++;
         end else begin
            set_dropped = 1;
         end
         if (w.last_interval) begin
            n = set_count;
            for (i = 0; i < n; i++) order[i] = i;
            for (i = 1; i < n; i++) begin
               key = order[i];
               j = i;
               while (j > 0 && set_end[order[j-1]] > set_end[key]) begin
                  order[j] = order[j-1];
                  j--;
               end
               order[j] = key;
            end
            any = 0;
            for (i = 0; i < n; i++) begin
               idx = order[i];
               if (i == 0 || set_start[idx] >= finish_mark) begin
                  finish_mark = set_end[idx];
                  r.interval_number = 7'(idx + 1);
                  r.last_result = 0;
                  r.overflow = set_dropped;
                  expected_picks = {expected_picks, r};
                  any = 1;
               end
            end
            if (any) expected_picks[$].last_result = 1;
            set_count = 0;
            set_dropped = 0;
            sets_done++;
         end
      end
   endtask

   function automatic bit idle_roll();
      return !quiet_mode && ($urandom_range(99) < 30);
   endfunction

   // Driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_word(req_word);
            words_sent++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled word
         end else if (pause_marks.size() > 0 && pause_marks[0] == words_sent &&
                      (expected_picks.size() > 0 || !hold_send)) begin
            req_valid <= 0;
            if (!hold_send) hold_send = 1;
         end else if (pending_words.size() > 0 && !idle_roll()) begin
            if (hold_send) begin
               hold_send = 0;
               void'(pause_marks.pop_front());
            end
            req_word <= pending_words.pop_front();
            req_valid <= 1;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // Monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            picks_seen++;
            if (expected_picks.size() == 0) begin
               errors++;
               $display("%0t: unexpected word %p", $time, rsp_word);
            end else begin
               e = expected_picks.pop_front();
               if (rsp_word.interval_number !== e.interval_number ||
                   rsp_word.last_result !== e.last_result ||
                   rsp_word.overflow !== e.overflow) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $time, e, rsp_word);
               end
            end
         end
         rsp_stall <= idle_roll();
      end
   end

   task automatic add_word(input int s, input int e, input bit last);
      req_type w;
      begin
         w.start_time = 16'(s);
         w.end_time = 16'(e);
         w.last_interval = last;
         pending_words = {pending_words, w};
      end
   endtask

   task automatic add_random_set(input int n, input int span);
      int i, s, len;
      begin
         for (i = 0; i < n; i++) begin
            if ($urandom_range(9) == 0) begin
               add_word($urandom_range(65535), $urandom_range(65535), i == n - 1);
            end else begin
               s = $urandom_range(span);
               len = $urandom_range(span / 4 + 1);
               add_word(s, (s + len) > 65535 ? 65535 : s + len, i == n - 1);
            end
         end
      end
   endtask

   initial begin
      int total, n, i;
      reset = 1;
      req_valid = 0;
      rsp_stall = 0;
      req_word = '0;
      quiet_mode = 0;
      errors = 0;
      words_sent = 0;
      picks_seen = 0;
      sets_done = 0;
      hold_send = 0;
      set_count = 0;
      set_dropped = 0;
      finish_mark = 0;

      // directed: single, extremes, equal ends, touching, reversed time
      add_word(0, 0, 1);
      add_word(65535, 65535, 1);
      add_word(5, 10, 0); add_word(10, 20, 0); add_word(0, 10, 0); add_word(12, 10, 1);
      add_word(0, 65535, 0); add_word(65535, 0, 0); add_word(21845, 43690, 0);
      add_word(43690, 21845, 1);
      add_word(3, 7, 0); add_word(3, 7, 0); add_word(7, 7, 0); add_word(0, 5, 1);
      pause_marks = {pause_marks, pending_words.size()};
      // overflow: 66 words, last one dropped too
      for (i = 0; i < 66; i++) add_word(i, i + 1, i == 65);
      pause_marks = {pause_marks, pending_words.size()};
      add_random_set(64, 65535);
      total = pending_words.size();
      while (total < 460) begin
         n = ($urandom_range(9) == 0) ? $urandom_range(40, 64) : $urandom_range(1, 12);
         if (n > 460 - total) n = 460 - total;
         add_random_set(n, ($urandom_range(1) == 1) ? 200 : 65535);
         total += n;
         if (total > 250 && total < 300 && quiet_mode == 0) pause_marks = {pause_marks, total};
      end

      repeat (5) @(posedge clock);
      reset <= 0;

      wait (words_sent > 300);
      quiet_mode = 1;
      wait (words_sent > 380);
      quiet_mode = 0;
      wait (pending_words.size() == 0 && !req_valid && expected_picks.size() == 0);
      repeat (600) @(posedge clock);

      $display("Ran %0d words in %0d sets, checked %0d picks incl. overflow and ties.",
               words_sent, sets_done, picks_seen);
      if (errors == 0 && expected_picks.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end
endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/iss_pkg.sv
rtl/core/iss_front.sv
rtl/core/iss_queue.sv
rtl/core/iss_back.sv
rtl/core/interval_schedule_select.sv
tb/tb_interval_schedule_select.sv
